// ===== src/gdpf_pkg.sv =====
// Shared types and constants for the gcd distinct prime factor count unit.
`timescale 1ns / 1ps
package gdpf_pkg;

    localparam int OPERAND_WIDTH_DEF = 40;
    localparam int COUNT_WIDTH       = 4;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD_CHECK,
        S_GCD_DIV,
        S_GCD_UPD,
        S_FAC_START,
        S_FAC_DIV,
        S_FAC_UPD,
        S_FINISH
    } t_state;

    // Divider operand select.
    typedef enum logic {
        DIV_GCD,
        DIV_FAC
    } t_div_sel;

    typedef struct packed {
        logic     load;        // capture operands of a new transaction
        logic     div_start;   // load the divider
        t_div_sel div_sel;     // which operand pair feeds the divider
        logic     div_step;    // one restoring division step
        logic     gcd_update;  // p <= q, q <= p mod q
        logic     fac_init;    // rest <= gcd, candidate <= 2, count <= 1
        logic     fac_update;  // divide out the candidate or move to the next one
        logic     out_load;    // write the result register
    } t_cmd;

    typedef struct packed {
        logic q_zero;          // second Euclid operand is zero
        logic div_last;        // divider is on its final step
        logic found;           // current candidate already counted
        logic bound_exceeded;  // candidate > rest / candidate
        logic out_free;        // result register can take a new value
    } t_status;

endpackage

// ===== src/gcd_distinct_prime_factor_count_unit.sv =====
// Top level of the gcd distinct prime factor count unit.
`timescale 1ns / 1ps
// Usage:
// An input transaction (i_valid/o_ready) carries two unsigned operands. The unit
// forms their greatest common divisor by Euclid's algorithm and then counts the
// distinct primes dividing it by trial division with candidates 2, 3, 4, ...
// up to the square root of the remaining value. The output transaction
// (o_valid/i_ready) carries one plus that count, saturated at 15.
// Every modulo goes through one shared restoring divider that produces one
// quotient bit per cycle. Euclid's algorithm takes up to about 1.5 * OPERAND_WIDTH
// steps, and trial division tries up to about 2^(OPERAND_WIDTH/2) candidates.
// One transaction is worked on at a time; o_ready is high only while idle.
// The result sits in an output register, so a new transaction may be taken
// while the previous result waits; if the receiver still stalls when the next
// result is ready, the unit holds in its final state until the register frees.
// Reset (synchronous, active low) returns the controller to idle and drops o_valid.
module gcd_distinct_prime_factor_count_unit #(
    parameter int OPERAND_WIDTH = gdpf_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [OPERAND_WIDTH-1:0] i_first_value,
    input  logic [OPERAND_WIDTH-1:0] i_second_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output gdpf_pkg::t_count         o_coprime_divisor_count
);
    import gdpf_pkg::*;

    t_cmd    cmd;
    t_status status;

    gdpf_controller u_controller (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    gdpf_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_datapath (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cmd                   (cmd),
        .o_status                (status),
        .i_first_value           (i_first_value),
        .i_second_value          (i_second_value),
        .o_valid                 (o_valid),
        .i_ready                 (i_ready),
        .o_coprime_divisor_count (o_coprime_divisor_count)
    );

endmodule

// ===== src/gdpf_datapath.sv =====
// Datapath: Euclid and trial-division registers around a shared bit-serial divider.
`timescale 1ns / 1ps
module gdpf_datapath #(
    parameter int OPERAND_WIDTH = gdpf_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  gdpf_pkg::t_cmd            i_cmd,
    output gdpf_pkg::t_status         o_status,
    input  logic [OPERAND_WIDTH-1:0]  i_first_value,
    input  logic [OPERAND_WIDTH-1:0]  i_second_value,
    output logic                      o_valid,
    input  logic                      i_ready,
    output gdpf_pkg::t_count          o_coprime_divisor_count
);
    import gdpf_pkg::*;

    localparam int W     = OPERAND_WIDTH;
    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     r_p, r_q, r_rest, r_cand;
    logic [W-1:0]     r_den, r_quo;
    logic [W-1:0]     r_rem;
    logic [CNT_W-1:0] r_cnt;
    t_count           r_count;
    logic             r_found;
    logic             r_out_valid;
    t_count           r_out_count;

    logic [W:0]   rem_sh, diff;
    logic         rem_zero;
    logic         rest_gt_one;
    t_count       count_inc;
    t_count       final_count;

    assign rem_sh      = {r_rem, r_quo[W-1]};
    assign diff        = rem_sh - {1'b0, r_den};
    assign rem_zero    = (r_rem == '0);
    assign rest_gt_one = (r_rest > W'(1));
    assign count_inc   = (r_count == '1) ? r_count : r_count + t_count'(1);
    assign final_count = (rest_gt_one && r_count != '1) ? r_count + t_count'(1) : r_count;

    always_comb begin
        o_status.q_zero         = (r_q == '0);
        o_status.div_last       = (r_cnt == CNT_W'(W - 1));
        o_status.found          = r_found;
        o_status.bound_exceeded = (r_cand > r_quo);
        o_status.out_free       = !r_out_valid || i_ready;
    end

    // Shared restoring divider: quotient bits shift into r_quo, one per cycle.
    // The partial remainder stays below the divisor, so it always fits in W bits.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_cnt <= '0;
            if (i_cmd.div_sel == DIV_GCD) begin
                r_quo <= r_p;
                r_den <= r_q;
            end else begin
                r_quo <= r_rest;
                r_den <= r_cand;
            end
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (!diff[W]) begin
                r_rem <= diff[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_p <= i_first_value;
            r_q <= i_second_value;
        end else if (i_cmd.gcd_update) begin
            r_p <= r_q;
            r_q <= r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fac_init) begin
            r_rest  <= r_p;
            r_cand  <= W'(2);
            r_count <= t_count'(1);
            r_found <= 1'b0;
        end else if (i_cmd.fac_update) begin
            if (rem_zero) begin
                r_rest  <= r_quo;
                r_found <= 1'b1;
                if (!r_found) begin
                    r_count <= count_inc;
                end
            end else begin
                r_found <= 1'b0;
                r_cand  <= r_cand + W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_count <= final_count;
        end
    end

    assign o_valid                 = r_out_valid;
    assign o_coprime_divisor_count = r_out_count;

endmodule

// ===== src/gdpf_controller.sv =====
// Controller: sequences the Euclid loop, the trial-division loop and the result write.
`timescale 1ns / 1ps
module gdpf_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  gdpf_pkg::t_status i_status,
    output gdpf_pkg::t_cmd    o_cmd
);
    import gdpf_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_GCD_CHECK;
            end
            S_GCD_CHECK: begin
                n_state = i_status.q_zero ? S_FAC_START : S_GCD_DIV;
            end
            S_GCD_DIV: begin
                if (i_status.div_last) n_state = S_GCD_UPD;
            end
            S_GCD_UPD:   n_state = S_GCD_CHECK;
            S_FAC_START: n_state = S_FAC_DIV;
            S_FAC_DIV: begin
                if (i_status.div_last) n_state = S_FAC_UPD;
            end
            S_FAC_UPD: begin
                // The bound applies only when moving on to a fresh candidate.
                if (!i_status.found && i_status.bound_exceeded) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = S_FAC_START;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            S_GCD_CHECK: begin
                if (i_status.q_zero) begin
                    o_cmd.fac_init = 1'b1;
                end else begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_GCD;
                end
            end
            S_GCD_DIV:   o_cmd.div_step = 1'b1;
            S_GCD_UPD:   o_cmd.gcd_update = 1'b1;
            S_FAC_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_FAC;
            end
            S_FAC_DIV:   o_cmd.div_step = 1'b1;
            S_FAC_UPD: begin
                o_cmd.fac_update = i_status.found || !i_status.bound_exceeded;
            end
            S_FINISH:    o_cmd.out_load = i_status.out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
